/* hdl/pls_pkg.sv */
`timescale 1ns / 1ps

package pls_pkg;

	localparam int FUNC_W   = 3;
	localparam int POS_W    = 4;
	localparam int VALUE_W  = 32;
	localparam int RD_W     = 32;
	localparam int SIZE_W   = 5;
	localparam int STATUS_W = 2;

	typedef enum logic [FUNC_W-1:0] {
		FN_INSERT   = 3'd0,
		FN_DELETE   = 3'd1,
		FN_RETRIEVE = 3'd2,
		FN_REPLACE  = 3'd3,
		FN_CLEAR    = 3'd4
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// What every cell does in a cycle
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_DELETE,
		CELL_WRITE
	} cell_op_t;

	typedef struct packed {
		cell_op_t          op;
		logic [POS_W-1:0]  pos;
	} cell_cmd_t;

endpackage

/* hdl/pls_cell.sv */
`timescale 1ns / 1ps

module pls_cell #(
	parameter int IDX        = 0,
	parameter int DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  pls_pkg::cell_cmd_t    cmd,
	input  logic [DATA_WIDTH-1:0] word,
	input  logic [DATA_WIDTH-1:0] left_data,
	input  logic [DATA_WIDTH-1:0] right_data,
	output logic [DATA_WIDTH-1:0] data_q
);
	import pls_pkg::*;

	localparam int IDX_BITS = (IDX > 0) ? $clog2(IDX + 1) : 1;
	localparam int CW       = (IDX_BITS > POS_W) ? IDX_BITS : POS_W;
	localparam logic [CW-1:0] MY_IDX = CW'(IDX);

	logic [CW-1:0] pos_x;
	logic          above;
	logic          here;

	assign pos_x = CW'(cmd.pos);
	assign above = MY_IDX > pos_x;
	assign here  = MY_IDX == pos_x;

	always_ff @(posedge clk) begin
		case (cmd.op)
			CELL_INSERT: begin
				// shift up above the slot, drop the new word into it
				if (above) begin
					data_q <= left_data;
				end else if (here) begin
					data_q <= word;
				end
			end
			CELL_DELETE: begin
				// close the gap: take the neighbor above
				if (above || here) begin
					data_q <= right_data;
				end
			end
			CELL_WRITE: begin
				if (here) begin
					data_q <= word;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

/* hdl/positional_list_store.sv */
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY words with insert/delete by position.
//
// Request channel (req_valid/req_ready): func, position, value. Functions
// are insert, delete, retrieve, replace and clear. Response channel
// (rsp_valid/rsp_ready): read_data, list_size, status, one beat for every
// request beat.
//
// A request's response is registered: it is shown from the cycle after
// the request is accepted. Throughput is one request per cycle while the
// receiver takes each beat. The list lives in a row of cells; each cell
// takes its neighbor's word, the new word or holds, so an insert or delete
// shifts the entries from the slot upward in the same cycle. The output register is the only thing setting the pace.
//
// When the receiver stalls, the response register holds its beat and
// req_ready drops until the beat is taken; a beat taken in the same cycle
// frees the slot for the next request at once.
//
// Reset clears the entry count and the response valid. Cell contents are
// not reset: an entry is only read below the count, after it was written.
// Rejected requests (bad position, full list) leave the list unchanged.
module positional_list_store #(
	parameter int CAPACITY   = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_ready,
	input  logic [pls_pkg::FUNC_W-1:0]     func,
	input  logic [pls_pkg::POS_W-1:0]      position,
	input  logic [pls_pkg::VALUE_W-1:0]    value,
	output logic                           rsp_valid,
	input  logic                           rsp_ready,
	output logic [pls_pkg::RD_W-1:0]       read_data,
	output logic [pls_pkg::SIZE_W-1:0]     list_size,
	output logic [pls_pkg::STATUS_W-1:0]   status
);
	import pls_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
	// only the first 2**POS_W entries can ever be addressed
	localparam int TAPS  = (CAPACITY < (1 << POS_W)) ? CAPACITY : (1 << POS_W);
	localparam int TAP_W = $clog2(TAPS);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

	logic [CNT_W-1:0]      count_q;
	logic                  rsp_valid_q;
	logic [RD_W-1:0]       read_data_q;
	logic [SIZE_W-1:0]     list_size_q;
	status_t               status_q;

	logic                  accept;
	logic [CMP_W-1:0]      cnt_x;
	logic [CMP_W-1:0]      pos_x;
	status_t               st;
	cell_op_t              op;
	logic [CNT_W-1:0]      cnt_nx;
	logic                  take_rd;
	cell_cmd_t             cmd;
	logic [DATA_WIDTH-1:0] word;
	logic [DATA_WIDTH-1:0] ent [CAPACITY];
	logic [DATA_WIDTH-1:0] rd_tap [TAPS];
	logic [DATA_WIDTH-1:0] rd_sel;

	// Free the request side whenever the response slot is empty or drains.
	assign req_ready = !rsp_valid_q || rsp_ready;
	assign accept    = req_valid && req_ready;

	assign cnt_x = CMP_W'(count_q);
	assign pos_x = CMP_W'(position);
	assign word  = DATA_WIDTH'(value);

	// Check the position and fullness, pick the row operation.
	always_comb begin
		st      = ST_OK;
		op      = CELL_HOLD;
		cnt_nx  = count_q;
		take_rd = 1'b0;
		case (func)
			FN_INSERT: begin
				if (pos_x > cnt_x) begin
					st = ST_RANGE;
				end else if (count_q == FULL_CNT) begin
					st = ST_FULL;
				end else begin
					op     = CELL_INSERT;
					cnt_nx = count_q + 1'b1;
				end
			end
			FN_DELETE: begin
				if (pos_x >= cnt_x) begin
					st = ST_RANGE;
				end else begin
					op      = CELL_DELETE;
					take_rd = 1'b1;
					cnt_nx  = count_q - 1'b1;
				end
			end
			FN_RETRIEVE: begin
				if (pos_x >= cnt_x) begin
					st = ST_RANGE;
				end else begin
					take_rd = 1'b1;
				end
			end
			FN_REPLACE: begin
				if (pos_x >= cnt_x) begin
					st = ST_RANGE;
				end else begin
					op = CELL_WRITE;
				end
			end
			FN_CLEAR: begin
				cnt_nx = '0;
			end
			default: begin
			end
		endcase
	end

	// Broadcast to the row only for an accepted beat.
	assign cmd.op  = accept ? op : CELL_HOLD;
	assign cmd.pos = position;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] left_d;
		logic [DATA_WIDTH-1:0] right_d;

		if (i == 0) begin : g_first
			assign left_d = '0;
		end else begin : g_mid_l
			assign left_d = ent[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_d = '0;
		end else begin : g_mid_r
			assign right_d = ent[i+1];
		end

		pls_cell #(
			.IDX        (i),
			.DATA_WIDTH (DATA_WIDTH)
		) u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.word       (word),
			.left_data  (left_d),
			.right_data (right_d),
			.data_q     (ent[i])
		);
	end

	for (genvar t = 0; t < TAPS; t++) begin : g_tap
		assign rd_tap[t] = ent[t];
	end

	assign rd_sel = rd_tap[position[TAP_W-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= cnt_nx;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Response payload: load on accept, hold otherwise.
	always_ff @(posedge clk) begin
		if (accept) begin
			read_data_q <= take_rd ? RD_W'(rd_sel) : '0;
			list_size_q <= SIZE_W'(cnt_nx);
			status_q    <= st;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign read_data = read_data_q;
	assign list_size = list_size_q;
	assign status    = status_q;

endmodule

/* hdl/pls_checker.sv */
`timescale 1ns / 1ps

module pls_checker #(
	parameter int CAPACITY   = 16
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           req_valid,
	input logic                           req_ready,
	input logic [pls_pkg::FUNC_W-1:0]     func,
	input logic                           rsp_valid,
	input logic                           rsp_ready,
	input logic [pls_pkg::RD_W-1:0]       read_data,
	input logic [pls_pkg::SIZE_W-1:0]     list_size,
	input logic [pls_pkg::STATUS_W-1:0]   status
);
	import pls_pkg::*;

	localparam logic [SIZE_W-1:0] FULL_SIZE = SIZE_W'(CAPACITY);

	// Every accepted request shows its response at the next edge.
	a_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> rsp_valid)
		else $error("response missing one cycle after request");

	// A clear empties the list.
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && func == FN_CLEAR |=>
			list_size == '0 && status == ST_OK)
		else $error("clear did not empty the list");

	// Full is only reported at capacity.
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_FULL |-> list_size == FULL_SIZE)
		else $error("full status below capacity");

	// A rejected request returns no data.
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != ST_OK |-> read_data == '0)
		else $error("data on rejected request");

	// A stalled response beat holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=>
			rsp_valid && $stable(read_data) && $stable(list_size) && $stable(status))
		else $error("stalled response changed");

endmodule

bind positional_list_store pls_checker #(
	.CAPACITY   (CAPACITY)
) u_pls_checker (.*);
